@@ rtl/framed_command_stepper_pulser_macros.svh @@
// assertion macros for the checks in the block's top-level file
`ifndef FRAMED_COMMAND_STEPPER_PULSER_MACROS_SVH
`define FRAMED_COMMAND_STEPPER_PULSER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FCSP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fcsp check failed");

// consequent must hold in the cycle after the antecedent
`define FCSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fcsp check failed");

`endif

@@ rtl/fcsp_pkg.sv @@
package fcsp_pkg;

    // framing limits
    localparam int MAX_FRAME_BYTES = 63;
    localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int KEEP_BYTES      = 3;

    typedef logic [LEN_W-1:0] t_len;

    // event codes
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // frame delimiters and command bytes
    localparam logic [7:0] FRAME_OPEN  = 8'hAA;
    localparam logic [7:0] FRAME_CLOSE = 8'h5A;
    localparam logic [7:0] CMD_SPEED   = 8'h01;
    localparam logic [7:0] CMD_STOP    = 8'h02;
    localparam logic [7:0] CMD_ANGLE   = 8'h03;
    localparam logic [7:0] DIR_FWD     = 8'h04;
    localparam logic [7:0] DIR_REV     = 8'h05;

    // pwm defaults
    localparam logic [8:0] DEFAULT_PERIOD        = 9'd20;
    localparam logic [7:0] DEFAULT_COMPARE       = 8'd10;
    localparam logic [7:0] RESET_PULSES_PER_UNIT = 8'd100;

    // response codes
    localparam logic [2:0] RESP_NONE    = 3'd0;
    localparam logic [2:0] RESP_OK      = 3'd1;
    localparam logic [2:0] RESP_PARAM   = 3'd2;
    localparam logic [2:0] RESP_ANGLE   = 3'd3;
    localparam logic [2:0] RESP_UNKNOWN = 3'd4;

    // a closed frame as seen by the command logic
    typedef struct packed {
        logic       run;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       len_ge2;
        logic       len_ge3;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic       step_level;
        logic       direction_level;
        logic       driver_disable;
        logic       pulse_mode;
        logic [2:0] response;
    } t_result;

endpackage

@@ rtl/fcsp_deframer.sv @@
module fcsp_deframer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_rx_byte,
    output fcsp_pkg::t_cmd    o_cmd
);

    logic           r_in_frame, n_in_frame;
    fcsp_pkg::t_len r_len, n_len;
    logic [7:0]     r_bytes [0:fcsp_pkg::KEEP_BYTES-1];
    logic [7:0]     n_bytes [0:fcsp_pkg::KEEP_BYTES-1];

    // frame state update for the item in the input register
    always_comb begin
        n_in_frame = r_in_frame;
        n_len      = r_len;
        n_bytes    = r_bytes;
        if (i_fire) begin
            case (i_opcode)
                fcsp_pkg::OP_BYTE: begin
                    if (!r_in_frame) begin
                        if (i_rx_byte == fcsp_pkg::FRAME_OPEN) begin
                            n_in_frame = 1'b1;
                            n_len      = '0;
                        end
                    end else if (i_rx_byte == fcsp_pkg::FRAME_CLOSE) begin
                        n_in_frame = 1'b0;
                        n_len      = '0;
                    end else if (r_len < fcsp_pkg::t_len'(fcsp_pkg::MAX_FRAME_BYTES)) begin
                        if (r_len < fcsp_pkg::t_len'(fcsp_pkg::KEEP_BYTES)) begin
                            n_bytes[r_len[1:0]] = i_rx_byte;
                        end
                        n_len = r_len + fcsp_pkg::t_len'(1);
                    end else begin
                        // overlong body aborts the frame
                        n_in_frame = 1'b0;
                        n_len      = '0;
                    end
                end
                fcsp_pkg::OP_TIMEOUT: begin
                    n_in_frame = 1'b0;
                    n_len      = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // frame registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_len      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_len      <= n_len;
        end
        r_bytes <= n_bytes;
    end

    // closing byte of a non-empty frame runs a command
    always_comb begin
        o_cmd.run     = (i_opcode == fcsp_pkg::OP_BYTE) && r_in_frame
                        && (i_rx_byte == fcsp_pkg::FRAME_CLOSE) && (r_len != '0);
        o_cmd.b0      = r_bytes[0];
        o_cmd.b1      = r_bytes[1];
        o_cmd.b2      = r_bytes[2];
        o_cmd.len_ge2 = (r_len >= fcsp_pkg::t_len'(2));
        o_cmd.len_ge3 = (r_len >= fcsp_pkg::t_len'(3));
    end

endmodule

@@ rtl/fcsp_motor.sv @@
module fcsp_motor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [1:0]          i_opcode,
    input  fcsp_pkg::t_cmd      i_cmd,
    input  logic [7:0]          i_pulses_per_unit,
    output fcsp_pkg::t_result   o_result
);

    logic [8:0]  r_speed_period, n_speed_period;
    logic [7:0]  r_speed_compare, n_speed_compare;
    logic [8:0]  r_live_period, n_live_period;
    logic [7:0]  r_live_compare, n_live_compare;
    logic [8:0]  r_tick, n_tick;
    logic        r_running, n_running;
    logic        r_counting, n_counting;
    logic [15:0] r_done, n_done;
    logic [15:0] r_target, n_target;
    logic        r_direction, n_direction;
    logic        r_disable, n_disable;
    logic [2:0]  w_response;
    logic [15:0] w_done_inc;
    logic [15:0] w_target_calc;

    assign w_done_inc    = r_done + 16'd1;
    assign w_target_calc = 16'(i_cmd.b1) * 16'(i_pulses_per_unit);

    // command execution and pwm tick
    always_comb begin
        n_speed_period  = r_speed_period;
        n_speed_compare = r_speed_compare;
        n_live_period   = r_live_period;
        n_live_compare  = r_live_compare;
        n_tick          = r_tick;
        n_running       = r_running;
        n_counting      = r_counting;
        n_done          = r_done;
        n_target        = r_target;
        n_direction     = r_direction;
        n_disable       = r_disable;
        w_response      = fcsp_pkg::RESP_NONE;
        if (i_fire && i_cmd.run) begin
            case (i_cmd.b0)
                fcsp_pkg::CMD_SPEED: begin
                    if (!i_cmd.len_ge3) begin
                        w_response = fcsp_pkg::RESP_PARAM;
                    end else begin
                        w_response = fcsp_pkg::RESP_OK;
                        if (i_cmd.b1 == fcsp_pkg::DIR_FWD || i_cmd.b1 == fcsp_pkg::DIR_REV) begin
                            n_direction     = (i_cmd.b1 == fcsp_pkg::DIR_REV);
                            n_speed_compare = i_cmd.b2;
                            n_speed_period  = {i_cmd.b2, 1'b0};
                            n_live_compare  = i_cmd.b2;
                            n_live_period   = {i_cmd.b2, 1'b0};
                            n_counting      = 1'b0;
                            n_tick          = '0;
                            n_done          = '0;
                            n_running       = 1'b1;
                            n_disable       = 1'b0;
                        end
                    end
                end
                fcsp_pkg::CMD_STOP: begin
                    w_response     = fcsp_pkg::RESP_OK;
                    n_live_period  = fcsp_pkg::DEFAULT_PERIOD;
                    n_live_compare = fcsp_pkg::DEFAULT_COMPARE;
                    n_disable      = 1'b1;
                    n_running      = 1'b0;
                    n_counting     = 1'b0;
                    n_done         = '0;
                end
                fcsp_pkg::CMD_ANGLE: begin
                    if (!i_cmd.len_ge2) begin
                        w_response = fcsp_pkg::RESP_ANGLE;
                    end else begin
                        w_response     = fcsp_pkg::RESP_OK;
                        n_target       = w_target_calc;
                        n_done         = '0;
                        n_live_period  = (r_speed_period == '0) ? fcsp_pkg::DEFAULT_PERIOD
                                                                 : r_speed_period;
                        n_live_compare = (r_speed_compare == '0) ? fcsp_pkg::DEFAULT_COMPARE
                                                                  : r_speed_compare;
                        n_tick         = '0;
                        n_running      = 1'b1;
                        n_counting     = 1'b1;
                    end
                end
                default: begin
                    w_response = fcsp_pkg::RESP_UNKNOWN;
                end
            endcase
        end else if (i_fire && i_opcode == fcsp_pkg::OP_TICK && r_running) begin
            if (r_tick >= r_live_period) begin
                // end of one pwm period
                n_tick = '0;
                if (r_counting) begin
                    n_done = w_done_inc;
                    if (w_done_inc >= r_target) begin
                        n_running  = 1'b0;
                        n_counting = 1'b0;
                        n_done     = '0;
                    end
                end
            end else begin
                n_tick = r_tick + 9'd1;
            end
        end
    end

    // motor state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_period  <= fcsp_pkg::DEFAULT_PERIOD;
            r_speed_compare <= fcsp_pkg::DEFAULT_COMPARE;
            r_live_period   <= fcsp_pkg::DEFAULT_PERIOD;
            r_live_compare  <= fcsp_pkg::DEFAULT_COMPARE;
            r_tick          <= '0;
            r_running       <= 1'b0;
            r_counting      <= 1'b0;
            r_done          <= '0;
            r_target        <= '0;
            r_direction     <= 1'b0;
            r_disable       <= 1'b0;
        end else begin
            r_speed_period  <= n_speed_period;
            r_speed_compare <= n_speed_compare;
            r_live_period   <= n_live_period;
            r_live_compare  <= n_live_compare;
            r_tick          <= n_tick;
            r_running       <= n_running;
            r_counting      <= n_counting;
            r_done          <= n_done;
            r_target        <= n_target;
            r_direction     <= n_direction;
            r_disable       <= n_disable;
        end
    end

    // levels after the update
    always_comb begin
        o_result.step_level      = n_running && (n_tick < {1'b0, n_live_compare});
        o_result.direction_level = n_direction;
        o_result.driver_disable  = n_disable;
        o_result.pulse_mode      = n_counting;
        o_result.response        = w_response;
    end

endmodule

@@ rtl/framed_command_stepper_pulser.sv @@
// Framed command stepper pulser.
// Input channel (i_valid / o_stall) carries one event per transfer: a received
// byte, a receive timeout or a prescaled timer tick (i_opcode, i_rx_byte).
// Output channel (o_valid / i_stall) returns exactly one result per event:
// step, direction and disable levels, pulse mode and a response code.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes pulses per unit;
// o_cfg_ready is always high; writes must be made while the block is idle, and
// the block itself does not enforce this. An event in the input register moves
// on into the result register when that register is empty or its result is
// taken, and o_valid rises with it. Throughput is one event per cycle while
// the receiver does not stall; all of the work is one pass of logic between
// the input register and the result register.
// When the receiver stalls, the result register holds; the input register can
// still take one more event, and o_stall rises once both are full.
// Synchronous reset clears the valid bits of both registers and the framing
// state, stops the pwm, sets the pwm to 20/10 and pulses per unit to 100.
module framed_command_stepper_pulser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_step_level,
    output logic       o_direction_level,
    output logic       o_driver_disable,
    output logic       o_pulse_mode,
    output logic [2:0] o_response,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic              r_in_valid;
    logic [1:0]        r_in_opcode;
    logic [7:0]        r_in_rx_byte;
    logic              r_out_valid;
    fcsp_pkg::t_result r_out;
    logic [7:0]        r_pulses_per_unit;
    logic              w_fire;
    logic              w_in_take;
    fcsp_pkg::t_cmd    w_cmd;
    fcsp_pkg::t_result w_result;

    // handshake
    assign w_fire      = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && !w_fire;
    assign w_in_take   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_take) begin
            r_in_opcode  <= i_opcode;
            r_in_rx_byte <= i_rx_byte;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulses_per_unit <= fcsp_pkg::RESET_PULSES_PER_UNIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pulses_per_unit <= i_cfg_data;
        end
    end

    fcsp_deframer u_deframer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_opcode  (r_in_opcode),
        .i_rx_byte (r_in_rx_byte),
        .o_cmd     (w_cmd)
    );

    fcsp_motor u_motor (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (w_fire),
        .i_opcode          (r_in_opcode),
        .i_cmd             (w_cmd),
        .i_pulses_per_unit (r_pulses_per_unit),
        .o_result          (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_step_level      = r_out.step_level;
    assign o_direction_level = r_out.direction_level;
    assign o_driver_disable  = r_out.driver_disable;
    assign o_pulse_mode      = r_out.pulse_mode;
    assign o_response        = r_out.response;

    // checks
    `include "framed_command_stepper_pulser_macros.svh"

    `FCSP_ASSERT_SAME(a_stall_only_when_full, o_stall, r_in_valid && r_out_valid && i_stall)
    `FCSP_ASSERT_NEXT(a_no_resp_off_byte, w_fire && r_in_opcode != fcsp_pkg::OP_BYTE,
                      r_out.response == fcsp_pkg::RESP_NONE)
    `FCSP_ASSERT_NEXT(a_held_item_kept, r_in_valid && r_out_valid && i_stall, r_in_valid)

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] OP_IGNORED = 2'd3;

    // levels that can be read straight off a stopped, freshly reset block
    localparam fcsp_pkg::t_result LV_NONE    = '0;
    localparam fcsp_pkg::t_result LV_UNKNOWN = '{1'b0, 1'b0, 1'b0, 1'b0,
                                                 fcsp_pkg::RESP_UNKNOWN};
    localparam fcsp_pkg::t_result LV_PARAM   = '{1'b0, 1'b0, 1'b0, 1'b0,
                                                 fcsp_pkg::RESP_PARAM};
    localparam fcsp_pkg::t_result LV_ANGLE   = '{1'b0, 1'b0, 1'b0, 1'b0,
                                                 fcsp_pkg::RESP_ANGLE};

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        data;
        logic              typed;
        fcsp_pkg::t_result want;
    } t_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [1:0] i_opcode    = fcsp_pkg::OP_BYTE;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_stall     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       o_stall;
    logic       o_valid;
    logic       o_step_level;
    logic       o_direction_level;
    logic       o_driver_disable;
    logic       o_pulse_mode;
    logic [2:0] o_response;
    logic       o_cfg_ready;

    // typed expectation travelling with the current event
    logic              row_typed = 1'b0;
    fcsp_pkg::t_result row_want  = '0;

    logic       idling     = 1'b1;
    int         stall_left = 0;
    int         fail_cnt   = 0;
    int         events_sent = 0;

    // shadow copy of the block state
    logic       frm_open;
    logic [7:0] frm_len;
    logic [7:0] frm_body [fcsp_pkg::KEEP_BYTES];
    logic [8:0] spd_period;
    logic [7:0] spd_cmp;
    logic [8:0] pwm_period;
    logic [7:0] pwm_cmp;
    logic [8:0] pwm_count;
    logic       pwm_on;
    logic       angle_on;
    logic [15:0] periods_done;
    logic [15:0] periods_goal;
    logic       dir_pin;
    logic       dis_pin;
    logic [7:0] ppu_reg;

    fcsp_pkg::t_result pending_levels [$];

    t_row directed_rows [28] = '{
        '{fcsp_pkg::OP_TICK,    8'h00,                 1'b1, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_OPEN,  1'b1, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    8'h07,                 1'b1, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_CLOSE, 1'b1, LV_UNKNOWN},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_OPEN,  1'b1, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::CMD_SPEED,   1'b1, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_CLOSE, 1'b1, LV_PARAM},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_OPEN,  1'b1, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::CMD_ANGLE,   1'b1, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_CLOSE, 1'b1, LV_ANGLE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_OPEN,  1'b1, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_CLOSE, 1'b1, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    8'hFF,                 1'b1, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_OPEN,  1'b0, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::CMD_SPEED,   1'b0, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::DIR_REV,     1'b0, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    8'h00,                 1'b0, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_CLOSE, 1'b0, LV_NONE},
        '{fcsp_pkg::OP_TICK,    8'h00,                 1'b0, LV_NONE},
        '{OP_IGNORED,           8'hFF,                 1'b0, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_OPEN,  1'b0, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::CMD_ANGLE,   1'b0, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    8'hFF,                 1'b0, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_CLOSE, 1'b0, LV_NONE},
        '{fcsp_pkg::OP_TIMEOUT, 8'h00,                 1'b0, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_OPEN,  1'b0, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::CMD_STOP,    1'b0, LV_NONE},
        '{fcsp_pkg::OP_BYTE,    fcsp_pkg::FRAME_CLOSE, 1'b0, LV_NONE}
    };

    framed_command_stepper_pulser u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (i_opcode),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_step_level      (o_step_level),
        .o_direction_level (o_direction_level),
        .o_driver_disable  (o_driver_disable),
        .o_pulse_mode      (o_pulse_mode),
        .o_response        (o_response),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // one event into the deframer and pwm, giving the levels after it
    function automatic fcsp_pkg::t_result stepper_next(input logic [1:0] op,
                                                       input logic [7:0] b);
        fcsp_pkg::t_result r;
        r = '0;
        case (op)
            fcsp_pkg::OP_BYTE: begin
                if (!frm_open) begin
                    if (b == fcsp_pkg::FRAME_OPEN) begin
                        frm_open = 1'b1;
                        frm_len  = '0;
                    end
                end else if (b == fcsp_pkg::FRAME_CLOSE) begin
                    frm_open = 1'b0;
                    if (frm_len != 0) begin
                        // command decode on the closed frame
                        if (frm_body[0] == fcsp_pkg::CMD_SPEED) begin
                            r.response = (frm_len < 3) ? fcsp_pkg::RESP_PARAM
                                                       : fcsp_pkg::RESP_OK;
                            if (frm_len >= 3 &&
                                (frm_body[1] == fcsp_pkg::DIR_FWD ||
                                 frm_body[1] == fcsp_pkg::DIR_REV)) begin
                                dir_pin      = (frm_body[1] == fcsp_pkg::DIR_REV);
                                spd_cmp      = frm_body[2];
                                spd_period   = {frm_body[2], 1'b0};
                                angle_on     = 1'b0;
                                pwm_count    = '0;
                                periods_done = '0;
                                pwm_on       = 1'b1;
                                dis_pin      = 1'b0;
                                pwm_period   = spd_period;
                                pwm_cmp      = spd_cmp;
                            end
                        end else if (frm_body[0] == fcsp_pkg::CMD_STOP) begin
                            r.response   = fcsp_pkg::RESP_OK;
                            pwm_period   = fcsp_pkg::DEFAULT_PERIOD;
                            pwm_cmp      = fcsp_pkg::DEFAULT_COMPARE;
                            dis_pin      = 1'b1;
                            pwm_on       = 1'b0;
                            angle_on     = 1'b0;
                            periods_done = '0;
                        end else if (frm_body[0] == fcsp_pkg::CMD_ANGLE) begin
                            if (frm_len < 2) begin
                                r.response = fcsp_pkg::RESP_ANGLE;
                            end else begin
                                r.response   = fcsp_pkg::RESP_OK;
                                periods_goal = 16'(frm_body[1]) * 16'(ppu_reg);
                                periods_done = '0;
                                pwm_period   = (spd_period == 0) ? fcsp_pkg::DEFAULT_PERIOD
                                                                 : spd_period;
                                pwm_cmp      = (spd_cmp == 0) ? fcsp_pkg::DEFAULT_COMPARE
                                                              : spd_cmp;
                                pwm_count    = '0;
                                pwm_on       = 1'b1;
                                angle_on     = 1'b1;
                            end
                        end else begin
                            r.response = fcsp_pkg::RESP_UNKNOWN;
                        end
                    end
                    frm_len = '0;
                end else if (frm_len < fcsp_pkg::MAX_FRAME_BYTES) begin
                    if (frm_len < fcsp_pkg::KEEP_BYTES) frm_body[frm_len[1:0]] = b;
                    frm_len = frm_len + 8'd1;
                end else begin
                    // overlong body aborts the frame
                    frm_open = 1'b0;
                    frm_len  = '0;
                end
            end
            fcsp_pkg::OP_TIMEOUT: begin
                frm_open = 1'b0;
                frm_len  = '0;
            end
            fcsp_pkg::OP_TICK: begin
                if (pwm_on) begin
                    if (pwm_count >= pwm_period) begin
                        pwm_count = '0;
                        if (angle_on) begin
                            periods_done = periods_done + 16'd1;
                            if (periods_done >= periods_goal) begin
                                pwm_on       = 1'b0;
                                angle_on     = 1'b0;
                                periods_done = '0;
                            end
                        end
                    end else begin
                        pwm_count = pwm_count + 9'd1;
                    end
                end
            end
            default: ;
        endcase
        r.step_level      = pwm_on && (pwm_count < {1'b0, pwm_cmp});
        r.direction_level = dir_pin;
        r.driver_disable  = dis_pin;
        r.pulse_mode      = angle_on;
        return r;
    endfunction

    // prediction on input transfers, checking on result transfers
    always @(posedge i_clk) begin
        fcsp_pkg::t_result calc;
        fcsp_pkg::t_result want;
        if (!i_rst_n) begin
            frm_open     = 1'b0;
            frm_len      = '0;
            frm_body     = '{8'h00, 8'h00, 8'h00};
            spd_period   = fcsp_pkg::DEFAULT_PERIOD;
            spd_cmp      = fcsp_pkg::DEFAULT_COMPARE;
            pwm_period   = fcsp_pkg::DEFAULT_PERIOD;
            pwm_cmp      = fcsp_pkg::DEFAULT_COMPARE;
            pwm_count    = '0;
            pwm_on       = 1'b0;
            angle_on     = 1'b0;
            periods_done = '0;
            periods_goal = '0;
            dir_pin      = 1'b0;
            dis_pin      = 1'b0;
            ppu_reg      = fcsp_pkg::RESET_PULSES_PER_UNIT;
            pending_levels.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) ppu_reg = i_cfg_data;
            if (i_valid && !o_stall) begin
                calc = stepper_next(i_opcode, i_rx_byte);
                pending_levels.push_back(row_typed ? row_want : calc);
            end
            if (o_valid && !i_stall) begin
                if (pending_levels.size() == 0) begin
                    $error("result transfer with nothing pending");
                    fail_cnt++;
                end else begin
                    want = pending_levels.pop_front();
                    if (o_step_level !== want.step_level) begin
                        $error("step_level: expected %0d, got %0d",
                               want.step_level, o_step_level);
                        fail_cnt++;
                    end
                    if (o_direction_level !== want.direction_level) begin
                        $error("direction_level: expected %0d, got %0d",
                               want.direction_level, o_direction_level);
                        fail_cnt++;
                    end
                    if (o_driver_disable !== want.driver_disable) begin
                        $error("driver_disable: expected %0d, got %0d",
                               want.driver_disable, o_driver_disable);
                        fail_cnt++;
                    end
                    if (o_pulse_mode !== want.pulse_mode) begin
                        $error("pulse_mode: expected %0d, got %0d",
                               want.pulse_mode, o_pulse_mode);
                        fail_cnt++;
                    end
                    if (o_response !== want.response) begin
                        $error("response: expected %0d, got %0d",
                               want.response, o_response);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // receiver back-pressure in random bursts, held off while idling is clear
    always @(posedge i_clk) begin
        if (!idling) begin
            i_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // one event transfer, with an optional sender gap ahead of it
    task automatic send_event(input logic [1:0] op, input logic [7:0] b,
                              input logic typed, input fcsp_pkg::t_result want);
        if (idling && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_opcode  <= op;
        i_rx_byte <= b;
        row_typed <= typed;
        row_want  <= want;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        events_sent++;
    endtask

    // hold the sender until every pending result has been seen
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_ppu(input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly well-formed frames and tick runs, with some aborts and noise
    task automatic random_phase(input int n_items);
        int         first;
        int         kind;
        int         len;
        int         k;
        logic [7:0] cmd;
        logic [7:0] arg1;
        logic [7:0] arg2;
        logic [7:0] b;
        first = events_sent;
        while (events_sent - first < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                k = $urandom_range(0, 9);
                if (k < 3)      cmd = fcsp_pkg::CMD_SPEED;
                else if (k < 5) cmd = fcsp_pkg::CMD_STOP;
                else if (k < 8) cmd = fcsp_pkg::CMD_ANGLE;
                else            cmd = 8'($urandom);
                if (cmd == fcsp_pkg::CMD_SPEED && $urandom_range(0, 4) != 0)
                    arg1 = $urandom_range(0, 1) ? fcsp_pkg::DIR_REV : fcsp_pkg::DIR_FWD;
                else if ($urandom_range(0, 3) == 0)
                    arg1 = 8'($urandom);
                else
                    arg1 = 8'($urandom_range(0, 3));
                arg2 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
                len  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 3;
                send_event(fcsp_pkg::OP_BYTE, fcsp_pkg::FRAME_OPEN, 1'b0, LV_NONE);
                send_event(fcsp_pkg::OP_BYTE, cmd, 1'b0, LV_NONE);
                if (len >= 2) send_event(fcsp_pkg::OP_BYTE, arg1, 1'b0, LV_NONE);
                if (len >= 3) send_event(fcsp_pkg::OP_BYTE, arg2, 1'b0, LV_NONE);
                for (k = 3; k < len; k++)
                    send_event(fcsp_pkg::OP_BYTE, 8'($urandom), 1'b0, LV_NONE);
                send_event(fcsp_pkg::OP_BYTE, fcsp_pkg::FRAME_CLOSE, 1'b0, LV_NONE);
            end else if (kind < 84) begin
                repeat ($urandom_range(1, 48))
                    send_event(fcsp_pkg::OP_TICK, 8'($urandom), 1'b0, LV_NONE);
            end else if (kind < 89) begin
                // timeout in the middle of a frame
                send_event(fcsp_pkg::OP_BYTE, fcsp_pkg::FRAME_OPEN, 1'b0, LV_NONE);
                repeat ($urandom_range(0, 3))
                    send_event(fcsp_pkg::OP_BYTE, 8'($urandom), 1'b0, LV_NONE);
                send_event(fcsp_pkg::OP_TIMEOUT, 8'($urandom), 1'b0, LV_NONE);
                send_event(fcsp_pkg::OP_BYTE, fcsp_pkg::FRAME_CLOSE, 1'b0, LV_NONE);
            end else if (kind < 91) begin
                // body around the length limit
                send_event(fcsp_pkg::OP_BYTE, fcsp_pkg::FRAME_OPEN, 1'b0, LV_NONE);
                len = $urandom_range(fcsp_pkg::MAX_FRAME_BYTES - 1,
                                     fcsp_pkg::MAX_FRAME_BYTES + 2);
                for (k = 0; k < len; k++) begin
                    b = 8'($urandom);
                    if (b == fcsp_pkg::FRAME_CLOSE) b = ~b;
                    send_event(fcsp_pkg::OP_BYTE, b, 1'b0, LV_NONE);
                end
                send_event(fcsp_pkg::OP_BYTE, fcsp_pkg::FRAME_CLOSE, 1'b0, LV_NONE);
            end else begin
                send_event(2'($urandom_range(0, 3)), 8'($urandom), 1'b0, LV_NONE);
            end
        end
    endtask

    // stimulus sequence
    initial begin
        int i;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < $size(directed_rows); i++)
            send_event(directed_rows[i].op, directed_rows[i].data,
                       directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        // reset value of pulses per unit first, then the extremes and others
        random_phase(110);
        drain_results();
        write_ppu(8'd1);
        random_phase(120);
        drain_results();
        write_ppu(8'd255);
        idling <= 1'b0;
        random_phase(100);
        drain_results();
        write_ppu(8'd0);
        idling <= 1'b1;
        random_phase(100);
        drain_results();
        write_ppu(8'd2);
        random_phase(120);
        drain_results();
        write_ppu(8'($urandom_range(1, 255)));
        idling <= 1'b0;
        random_phase(120);
        drain_results();

        if (pending_levels.size() != 0) fail_cnt++;
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ framed_command_stepper_pulser.f @@
+incdir+rtl
rtl/fcsp_pkg.sv
rtl/fcsp_deframer.sv
rtl/fcsp_motor.sv
rtl/framed_command_stepper_pulser.sv
test/tb_top.sv
